### hdl/bsfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsfb_pkg;

	localparam int RUN_MAX = 9;
	localparam int CNT_W   = 4;
	localparam int CODE_W  = 4;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] CFG_FLAG       = 3'd0;
	localparam logic [IDX_W-1:0] CFG_ESCAPE     = 3'd1;
	localparam logic [IDX_W-1:0] CFG_SUB_FLAG   = 3'd2;
	localparam logic [IDX_W-1:0] CFG_SUB_ESCAPE = 3'd3;
	localparam logic [IDX_W-1:0] CFG_INFO_CODE  = 3'd4;

	localparam logic [7:0]        FLAG_RST       = 8'h7E;
	localparam logic [7:0]        ESCAPE_RST     = 8'h7D;
	localparam logic [7:0]        SUB_FLAG_RST   = 8'h5E;
	localparam logic [7:0]        SUB_ESCAPE_RST = 8'h5D;
	localparam logic [CODE_W-1:0] INFO_CODE_RST  = 4'h0;

	typedef struct packed {
		logic [7:0]        flag;
		logic [7:0]        escape;
		logic [7:0]        sub_flag;
		logic [7:0]        sub_escape;
		logic [CODE_W-1:0] info_code;
	} cfg_t;

	// All line bytes caused by one accepted word.
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]        count;
		logic                    close;
	} run_t;

	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
	} stuff_t;

	function automatic stuff_t stuff_byte(input logic [7:0] b, input cfg_t c);
		stuff_t s;
		s.two = 1'b1;
		s.b0  = c.escape;
		s.b1  = c.sub_flag;
		if (b == c.flag) begin
			s.b1 = c.sub_flag;
		end else if (b == c.escape) begin
			s.b1 = c.sub_escape;
		end else begin
			s.two = 1'b0;
			s.b0  = b;
			s.b1  = b;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

### hdl/byte_stuffed_frame_builder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-stuffed frame builder.
// Input channel (in_valid/in_ready): one word carries an optional frame start
// (address, command), an optional payload byte and an optional frame end.
// Output channel (out_valid/out_ready): one line byte per transfer, with
// last_of_run on the final byte caused by an input word and frame_done on
// the closing flag.
// Configuration: cfg_wr_en/cfg_index/cfg_data write the flag, escape,
// substitute and information-code registers; write only while idle.
// Timing: the first line byte of an input word is offered the cycle after
// the word is accepted. An input word causes at most 9 line bytes; the
// next word is accepted in the same cycle as the last byte of the previous
// run is taken, so the link has no gaps while words that cause bytes keep
// arriving. A word that causes no bytes is accepted without loading a run.
// A stalled receiver holds the current byte and, once the run buffer is
// full, in_ready drops until the last byte of the run is taken.
// Reset clears the frame state and the run buffer and loads the default
// register values (flag 7E, escape 7D, substitutes 5E/5D, code 0).
module byte_stuffed_frame_builder_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr_en,
	input  wire  [bsfb_pkg::IDX_W-1:0]  cfg_index,
	input  wire  [7:0]                  cfg_data,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire                         start_frame,
	input  wire  [7:0]                  address,
	input  wire  [7:0]                  command,
	input  wire                         has_byte,
	input  wire  [7:0]                  data_byte,
	input  wire                         end_frame,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [7:0]                  out_byte,
	output logic                        last_of_run,
	output logic                        frame_done
);

	bsfb_pkg::cfg_t cfg;
	bsfb_pkg::run_t run;
	logic           accept;
	logic           free;

	assign in_ready = free;
	assign accept   = in_valid && free;

	bsfb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bsfb_encoder u_enc (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.accept      (accept),
		.start_frame (start_frame),
		.address     (address),
		.command     (command),
		.has_byte    (has_byte),
		.data_byte   (data_byte),
		.end_frame   (end_frame),
		.run         (run)
	);

	bsfb_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept && (run.count != '0)),
		.run         (run),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

endmodule

`default_nettype wire

### hdl/bsfb_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module bsfb_cfg_regs (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr_en,
	input  wire  [bsfb_pkg::IDX_W-1:0]  cfg_index,
	input  wire  [7:0]                  cfg_data,
	output bsfb_pkg::cfg_t              cfg
);

	bsfb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag       <= bsfb_pkg::FLAG_RST;
			cfg_q.escape     <= bsfb_pkg::ESCAPE_RST;
			cfg_q.sub_flag   <= bsfb_pkg::SUB_FLAG_RST;
			cfg_q.sub_escape <= bsfb_pkg::SUB_ESCAPE_RST;
			cfg_q.info_code  <= bsfb_pkg::INFO_CODE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bsfb_pkg::CFG_FLAG:       cfg_q.flag       <= cfg_data;
				bsfb_pkg::CFG_ESCAPE:     cfg_q.escape     <= cfg_data;
				bsfb_pkg::CFG_SUB_FLAG:   cfg_q.sub_flag   <= cfg_data;
				bsfb_pkg::CFG_SUB_ESCAPE: cfg_q.sub_escape <= cfg_data;
				bsfb_pkg::CFG_INFO_CODE:  cfg_q.info_code  <= cfg_data[bsfb_pkg::CODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hdl/bsfb_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

module bsfb_encoder (
	input  wire              clk,
	input  wire              arst_n,
	input  bsfb_pkg::cfg_t   cfg,
	input  wire              accept,
	input  wire              start_frame,
	input  wire  [7:0]       address,
	input  wire  [7:0]       command,
	input  wire              has_byte,
	input  wire  [7:0]       data_byte,
	input  wire              end_frame,
	output bsfb_pkg::run_t   run
);

	logic       in_frame_q;
	logic       info_q;
	logic       seen_q;
	logic [7:0] xor_q;

	logic       in_frame_d;
	logic       info_d;
	logic       seen_d;
	logic [7:0] xor_d;

	always_comb begin
		logic [bsfb_pkg::CNT_W-1:0] cnt;
		logic       frm;
		logic       inf;
		logic       seen;
		logic [7:0] acc;
		logic       take;
		logic       close;
		bsfb_pkg::stuff_t sd;
		bsfb_pkg::stuff_t sx;

		frm  = in_frame_q;
		inf  = info_q;
		seen = seen_q;
		acc  = xor_q;
		cnt  = '0;
		for (int k = 0; k < bsfb_pkg::RUN_MAX; k++) begin
			run.bytes[k] = cfg.flag;
		end

		if (start_frame) begin
			run.bytes[0] = cfg.flag;
			run.bytes[1] = address;
			run.bytes[2] = command;
			run.bytes[3] = address ^ command;
			cnt  = 4'd4;
			frm  = 1'b1;
			inf  = (command[bsfb_pkg::CODE_W-1:0] == cfg.info_code);
			seen = 1'b0;
			acc  = 8'h00;
		end

		take = has_byte && frm && inf;
		sd   = bsfb_pkg::stuff_byte(data_byte, cfg);
		if (take) begin
			acc  = acc ^ data_byte;
			seen = 1'b1;
			run.bytes[cnt] = sd.b0;
			cnt = cnt + 4'd1;
			if (sd.two) begin
				run.bytes[cnt] = sd.b1;
				cnt = cnt + 4'd1;
			end
		end

		// check byte (only if a payload byte was taken) then closing flag
		close = end_frame && frm;
		sx    = bsfb_pkg::stuff_byte(acc, cfg);
		if (close) begin
			if (seen) begin
				run.bytes[cnt] = sx.b0;
				cnt = cnt + 4'd1;
				if (sx.two) begin
					run.bytes[cnt] = sx.b1;
					cnt = cnt + 4'd1;
				end
			end
			run.bytes[cnt] = cfg.flag;
			cnt  = cnt + 4'd1;
			frm  = 1'b0;
			inf  = 1'b0;
			seen = 1'b0;
			acc  = 8'h00;
		end

		run.count  = cnt;
		run.close  = close;
		in_frame_d = frm;
		info_d     = inf;
		seen_d     = seen;
		xor_d      = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			info_q     <= 1'b0;
			seen_q     <= 1'b0;
			xor_q      <= 8'h00;
		end else if (accept) begin
			in_frame_q <= in_frame_d;
			info_q     <= info_d;
			seen_q     <= seen_d;
			xor_q      <= xor_d;
		end
	end

endmodule

`default_nettype wire

### hdl/bsfb_serializer.sv
`timescale 1ns / 1ps
`default_nettype none

module bsfb_serializer (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              load,
	input  bsfb_pkg::run_t   run,
	output logic             free,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic             frame_done
);

	logic [bsfb_pkg::RUN_MAX-1:0][7:0] bytes_q;
	logic [bsfb_pkg::CNT_W-1:0] count_q;
	logic                       close_q;
	logic                       valid_q;
	logic [bsfb_pkg::CNT_W-1:0] idx_q;
	logic                       last;

	assign last        = (idx_q == count_q - 4'd1);
	assign free        = !valid_q || (out_ready && last);
	assign out_valid   = valid_q;
	assign out_byte    = bytes_q[idx_q];
	assign last_of_run = last;
	assign frame_done  = last && close_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (last) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= run.bytes;
			count_q <= run.count;
			close_q <= run.close;
		end
	end

endmodule

`default_nettype wire

### tb/byte_stuffed_frame_builder_unit_tb.sv
`timescale 1ns / 1ps

module byte_stuffed_frame_builder_unit_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic       start;
		logic [7:0] addr;
		logic [7:0] cmd;
		logic       has;
		logic [7:0] data;
		logic       stop;
	} word_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       done;
	} line_byte_t;

	class frame_scoreboard;
		bsfb_pkg::cfg_t cfg;
		bit         in_frame;
		bit         info_on;
		bit         seen;
		logic [7:0] xsum;
		line_byte_t line_q[$];
		line_byte_t run[$];
		int         errors;

		function new();
			cfg.flag       = bsfb_pkg::FLAG_RST;
			cfg.escape     = bsfb_pkg::ESCAPE_RST;
			cfg.sub_flag   = bsfb_pkg::SUB_FLAG_RST;
			cfg.sub_escape = bsfb_pkg::SUB_ESCAPE_RST;
			cfg.info_code  = bsfb_pkg::INFO_CODE_RST;
			in_frame = 0;
			info_on  = 0;
			seen     = 0;
			xsum     = '0;
			errors   = 0;
		endfunction

		function void put(logic [7:0] b, logic done);
			line_byte_t e;
			e.b    = b;
			e.last = 1'b0;
			e.done = done;
			run.push_back(e);
		endfunction

		// flag wins when flag and escape registers hold the same value
		function void put_escaped(logic [7:0] b);
			if (b == cfg.flag) begin
				put(cfg.escape, 1'b0);
				put(cfg.sub_flag, 1'b0);
			end else if (b == cfg.escape) begin
				put(cfg.escape, 1'b0);
				put(cfg.sub_escape, 1'b0);
			end else begin
				put(b, 1'b0);
			end
		endfunction

		function void note_word(word_t w);
			run.delete();
			if (w.start) begin
				put(cfg.flag, 1'b0);
				put(w.addr, 1'b0);
				put(w.cmd, 1'b0);
				put(w.addr ^ w.cmd, 1'b0);
				in_frame = 1;
				info_on  = (w.cmd[3:0] == cfg.info_code);
				seen     = 0;
				xsum     = '0;
			end
			if (w.has && in_frame && info_on) begin
				xsum = xsum ^ w.data;
				seen = 1;
				put_escaped(w.data);
			end
			if (w.stop && in_frame) begin
				if (seen)
					put_escaped(xsum);
				put(cfg.flag, 1'b1);
				in_frame = 0;
				info_on  = 0;
				seen     = 0;
				xsum     = '0;
			end
			foreach (run[i]) begin
				if (i == run.size() - 1)
					run[i].last = 1'b1;
				line_q.push_back(run[i]);
			end
		endfunction

		function void check_byte(logic [7:0] b, logic last, logic done);
			line_byte_t e;
			if (line_q.size() == 0) begin
				$error("unexpected line byte %h (last %b done %b)", b, last, done);
				errors++;
				return;
			end
			e = line_q.pop_front();
			if (b !== e.b) begin
				$error("out_byte: expected %h, got %h", e.b, b);
				errors++;
			end
			if (last !== e.last) begin
				$error("last_of_run: expected %b, got %b", e.last, last);
				errors++;
			end
			if (done !== e.done) begin
				$error("frame_done: expected %b, got %b", e.done, done);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [bsfb_pkg::IDX_W-1:0] cfg_index = '0;
	logic [7:0]       cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             start_frame = 1'b0;
	logic [7:0]       address = '0;
	logic [7:0]       command = '0;
	logic             has_byte = 1'b0;
	logic [7:0]       data_byte = '0;
	logic             end_frame = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       out_byte;
	logic             last_of_run;
	logic             frame_done;

	frame_scoreboard sb;
	bit              no_idle = 0;
	bit              rx_hold_req = 0;
	int              cycles = 0;
	int              words_sent;

	byte_stuffed_frame_builder_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_frame (start_frame),
		.address     (address),
		.command     (command),
		.has_byte    (has_byte),
		.data_byte   (data_byte),
		.end_frame   (end_frame),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_byte(out_byte, last_of_run, frame_done);
	end

	// mostly zero, some short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver: random stalls plus one long hold-off on request
	initial begin
		int rx_wait;
		rx_wait = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 0;
				rx_wait = LONG_HOLD;
			end
			if (rx_wait > 0) begin
				out_ready <= 1'b0;
				rx_wait--;
			end else begin
				out_ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					rx_wait = gap_len();
			end
		end
	end

	function automatic word_t mk(logic s, logic [7:0] a, logic [7:0] c, logic h,
			logic [7:0] d, logic e);
		word_t w;
		w.start = s;
		w.addr  = a;
		w.cmd   = c;
		w.has   = h;
		w.data  = d;
		w.stop  = e;
		return w;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_word(word_t w);
		int gap;
		gap = no_idle ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		start_frame <= w.start;
		address     <= w.addr;
		command     <= w.cmd;
		has_byte    <= w.has;
		data_byte   <= w.data;
		end_frame   <= w.stop;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.line_q.size() > 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(bsfb_pkg::cfg_t c);
		cfg_wr_en <= 1'b1;
		cfg_index <= bsfb_pkg::CFG_FLAG;
		cfg_data  <= c.flag;
		@(negedge clk);
		cfg_index <= bsfb_pkg::CFG_ESCAPE;
		cfg_data  <= c.escape;
		@(negedge clk);
		cfg_index <= bsfb_pkg::CFG_SUB_FLAG;
		cfg_data  <= c.sub_flag;
		@(negedge clk);
		cfg_index <= bsfb_pkg::CFG_SUB_ESCAPE;
		cfg_data  <= c.sub_escape;
		@(negedge clk);
		cfg_index <= bsfb_pkg::CFG_INFO_CODE;
		cfg_data  <= {4'h0, c.info_code};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.cfg = c;
		@(negedge clk);
	endtask

	// payload biased toward the bytes that need escaping
	function automatic logic [7:0] pick_data();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1: return sb.cfg.flag;
			2, 3: return sb.cfg.escape;
			4: return sb.cfg.sub_flag;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_cmd();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) != 0)
			c[3:0] = sb.cfg.info_code;
		return c;
	endfunction

	task automatic drive_frame();
		int n;
		n = $urandom_range(0, 6);
		if (n == 0) begin
			send_word(mk(1'b1, 8'($urandom_range(0, 255)), pick_cmd(),
				1'($urandom_range(0, 1)), pick_data(), 1'b1));
		end else begin
			send_word(mk(1'b1, 8'($urandom_range(0, 255)), pick_cmd(),
				1'($urandom_range(0, 1)), pick_data(), 1'b0));
			for (int i = 1; i < n; i++)
				send_word(mk($urandom_range(0, 19) == 0, 8'($urandom_range(0, 255)),
					pick_cmd(), $urandom_range(0, 7) != 0, pick_data(), 1'b0));
			// some frames are left open and get abandoned by the next start
			send_word(mk(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), pick_data(), $urandom_range(0, 7) != 0));
		end
	endtask

	task automatic run_random(int n_words);
		words_sent = 0;
		while (words_sent < n_words) begin
			if ($urandom_range(0, 6) == 0)
				send_word(mk(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
			else
				drive_frame();
		end
	endtask

	initial begin
		bsfb_pkg::cfg_t c;
		sb = new();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset register values
		send_word(mk(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
		send_word(mk(1'b0, 8'hAA, 8'h55, 1'b1, 8'h55, 1'b1));
		send_word(mk(1'b1, 8'h00, 8'h00, 1'b1, 8'h7E, 1'b1));
		send_word(mk(1'b1, 8'hFF, 8'hF0, 1'b1, 8'h7D, 1'b0));
		send_word(mk(1'b0, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0));
		send_word(mk(1'b0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0));
		send_word(mk(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
		send_word(mk(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1));
		send_word(mk(1'b1, 8'h12, 8'h01, 1'b1, 8'h7E, 1'b0));
		send_word(mk(1'b0, 8'h00, 8'h00, 1'b1, 8'h7D, 1'b1));
		send_word(mk(1'b1, 8'hA5, 8'h10, 1'b0, 8'h00, 1'b0));
		send_word(mk(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1));
		send_word(mk(1'b1, 8'h33, 8'h40, 1'b1, 8'h12, 1'b0));
		send_word(mk(1'b1, 8'hFF, 8'h0F, 1'b1, 8'h34, 1'b0));
		send_word(mk(1'b1, 8'h7E, 8'h70, 1'b1, 8'h5E, 1'b0));
		send_word(mk(1'b0, 8'h00, 8'h00, 1'b1, 8'h5E, 1'b1));
		send_word(mk(1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1));
		send_word(mk(1'b1, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1));
		wait_idle();

		run_random(15);
		wait_idle();

		// distinct extremes, with a long receiver hold-off against a busy sender
		c.flag = 8'h00; c.escape = 8'hFF; c.sub_flag = 8'hFF; c.sub_escape = 8'h00;
		c.info_code = 4'hF;
		set_config(c);
		no_idle = 1;
		rx_hold_req = 1;
		run_random(15);
		no_idle = 0;
		wait_idle();

		// flag and escape equal
		c.flag = 8'h7E; c.escape = 8'h7E; c.sub_flag = 8'h5E; c.sub_escape = 8'h5D;
		c.info_code = 4'h3;
		set_config(c);
		run_random(15);
		wait_idle();

		c.flag = 8'hFF; c.escape = 8'hFF; c.sub_flag = 8'hFF; c.sub_escape = 8'hFF;
		c.info_code = 4'hF;
		set_config(c);
		run_random(10);
		wait_idle();

		c.flag = 8'h00; c.escape = 8'h00; c.sub_flag = 8'h00; c.sub_escape = 8'h00;
		c.info_code = 4'h0;
		set_config(c);
		run_random(10);
		wait_idle();

		c.flag = 8'($urandom_range(0, 255)); c.escape = 8'($urandom_range(0, 255));
		c.sub_flag = 8'($urandom_range(0, 255)); c.sub_escape = 8'($urandom_range(0, 255));
		c.info_code = 4'($urandom_range(0, 15));
		set_config(c);
		no_idle = 1;
		run_random(5);
		no_idle = 0;
		run_random(5);
		wait_idle();

		if (sb.line_q.size() != 0) begin
			$error("%0d expected line bytes never arrived", sb.line_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
